// ===== rtl/shkm_pkg.sv =====
// Package for the string hash key mixer: word type, initial words and mixing constants.
// No dependencies; used by string_hash_key_mixer.
`default_nettype none

package shkm_pkg;

    typedef logic [31:0] word_t;

    // initial words loaded by the first item of a string
    localparam word_t INIT_W0 = 32'h6c078965;
    localparam word_t INIT_W1 = 32'h9908b0df;
    localparam word_t INIT_W2 = 32'h9d2c5680;
    localparam word_t INIT_W3 = 32'hefc60000;

    // multiplier constants and the finalisation addend
    localparam word_t K_BYTE  = 32'h85ebca77;
    localparam word_t K_MIX1  = 32'hcc9e2d51;
    localparam word_t K_MIX2  = 32'h1b873593;
    localparam word_t K_MIX3  = 32'h85ebca6b;
    localparam word_t K_MIX4  = 32'hc2b2ae35;
    localparam word_t K_FIN   = 32'h5bd1e995;
    localparam word_t ADD_FIN = 32'hffff0000;

    localparam int unsigned NUM_WORDS  = 4;
    localparam int unsigned FIN_ROUNDS = 8;

endpackage

`default_nettype wire

// ===== rtl/string_hash_key_mixer.sv =====
// String hash key mixer top level: sequencer around one shared 32x32 multiply-add unit.
// Depends on shkm_pkg.
`default_nettype none

// Takes a string one byte per input transfer and returns an 8-byte key on the transfer
// flagged is_last. The first transfer of a string (is_first) loads the four mixing words
// from fixed constants, with seed_word folded into word 0 and string_length into word 1,
// and clears the byte index. Each transfer with has_byte set absorbs its byte; a transfer
// with has_byte clear absorbs nothing, so an empty string is one transfer with is_first
// and is_last set and has_byte clear. All arithmetic runs through a single registered
// 32x32 multiply-add unit stepped by a small sequencer, and in_ready is high only while
// the sequencer is idle. After the accept step a byte takes six sequencer steps: five
// multiplies in a dependent chain and a write-back. A last transfer adds the eight
// finalisation rounds (a multiply step and a write-back step a round) and then the load
// of the output register. The key sits in an output register; the next input transfer
// may be taken while it still waits for out_ready, and only a following key waits for
// that register to drain. key_bytes carries key byte k at bits 8k+7 down to 8k.
module string_hash_key_mixer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_value,
    input  wire logic        has_byte,
    input  wire logic        is_first,
    input  wire logic        is_last,
    input  wire logic [31:0] seed_word,
    input  wire logic [31:0] string_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      key_bytes
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_M0,   // rotate current word, multiply byte
        S_M1,   // fold byte product, first mix multiply with salt
        S_M2,   // store p1, second mix multiply
        S_M3,   // store q1, third mix multiply
        S_M4,   // store p2, fourth mix multiply
        S_M5,   // store q2, advance index
        S_F0,   // finalisation round: xor-shift and multiply-add
        S_F1,   // finalisation round: write back
        S_OUT   // load output register
    } state_t;

    state_t            state_reg, state_next;
    shkm_pkg::word_t   words_reg [shkm_pkg::NUM_WORDS];
    shkm_pkg::word_t   words_next [shkm_pkg::NUM_WORDS];
    logic [31:0]       idx_reg, idx_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [2:0]        round_reg, round_next;
    shkm_pkg::word_t   prod_reg, prod_next;
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       key_reg, key_next;

    // shared multiply-add unit operands; only the low word of the product is kept
    shkm_pkg::word_t   mul_a;
    shkm_pkg::word_t   mul_k;
    shkm_pkg::word_t   mul_add;
    shkm_pkg::word_t   mul_full;

    // word selects
    logic [1:0]        cur;
    logic [1:0]        nxt;
    logic [1:0]        fa;
    logic [1:0]        fb;
    logic [1:0]        fc;
    shkm_pkg::word_t   q0;
    shkm_pkg::word_t   fin_t;

    assign cur = idx_reg[1:0];
    assign nxt = idx_reg[1:0] + 2'd1;
    assign fa  = round_reg[1:0];
    assign fb  = round_reg[1:0] + 2'd1;
    assign fc  = round_reg[1:0] + 2'd2;

    assign q0    = words_reg[cur] ^ prod_reg;
    assign fin_t = words_reg[fa] ^ {words_reg[fb][20:0], 11'b0};

    assign mul_full  = mul_a * mul_k;
    assign prod_next = mul_full + mul_add;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign key_bytes = key_reg;

    always_comb
    begin
        state_next     = state_reg;
        words_next     = words_reg;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        round_next     = round_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_a          = '0;
        mul_k          = '0;
        mul_add        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = byte_value;
                    last_next = is_last;
                    if (is_first)
                    begin
                        words_next[0] = shkm_pkg::INIT_W0 ^ seed_word;
                        words_next[1] = shkm_pkg::INIT_W1 ^ string_length;
                        words_next[2] = shkm_pkg::INIT_W2;
                        words_next[3] = shkm_pkg::INIT_W3;
                        idx_next      = '0;
                    end
                    round_next = '0;
                    if (has_byte)
                        state_next = S_M0;
                    else if (is_last)
                        state_next = S_F0;
                end
            end
            S_M0:
            begin
                words_next[cur] = {words_reg[cur][24:0], words_reg[cur][31:25]};
                mul_a           = {24'b0, byte_reg};
                mul_k           = shkm_pkg::K_BYTE;
                state_next      = S_M1;
            end
            S_M1:
            begin
                // byte product folded into the current word; salt added after multiply
                words_next[cur] = q0;
                mul_a           = words_reg[nxt] ^ q0;
                mul_k           = shkm_pkg::K_MIX1;
                mul_add         = idx_reg;
                state_next      = S_M2;
            end
            S_M2:
            begin
                words_next[nxt] = prod_reg;
                mul_a           = words_reg[cur] ^ prod_reg;
                mul_k           = shkm_pkg::K_MIX2;
                state_next      = S_M3;
            end
            S_M3:
            begin
                words_next[cur] = prod_reg;
                mul_a           = words_reg[nxt] ^ {16'b0, words_reg[nxt][31:16]};
                mul_k           = shkm_pkg::K_MIX3;
                state_next      = S_M4;
            end
            S_M4:
            begin
                words_next[nxt] = prod_reg;
                mul_a           = words_reg[cur] ^ {13'b0, words_reg[cur][31:13]};
                mul_k           = shkm_pkg::K_MIX4;
                state_next      = S_M5;
            end
            S_M5:
            begin
                words_next[cur] = prod_reg;
                idx_next        = idx_reg + 32'd1;
                state_next      = last_reg ? S_F0 : S_IDLE;
            end
            S_F0:
            begin
                words_next[fc] = words_reg[fc] ^ {8'b0, fin_t[31:8]};
                mul_a          = fin_t;
                mul_k          = shkm_pkg::K_FIN;
                mul_add        = shkm_pkg::ADD_FIN;
                state_next     = S_F1;
            end
            S_F1:
            begin
                words_next[fa] = prod_reg;
                round_next     = round_reg + 3'd1;
                state_next     = (round_reg == 3'(shkm_pkg::FIN_ROUNDS - 1)) ? S_OUT : S_F0;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    key_next = {words_reg[3][31:24], words_reg[2][31:24],
                                words_reg[1][23:16], words_reg[0][23:16],
                                words_reg[3][15:8],  words_reg[2][15:8],
                                words_reg[1][7:0],   words_reg[0][7:0]};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < shkm_pkg::NUM_WORDS; i++)
                words_reg[i] <= '0;
            idx_reg       <= '0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            round_reg     <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            words_reg     <= words_next;
            idx_reg       <= idx_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            round_reg     <= round_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            key_reg       <= key_next;
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for string_hash_key_mixer: streams strings of random bytes, predicts
// each 64-bit key with its own hash model and checks every key transfer.
// Depends on the RTL in rtl/ (shkm_pkg for the word type, string_hash_key_mixer).
`timescale 1ns / 1ps

module tb;

    typedef shkm_pkg::word_t word_t;

    // Initial words and mixing constants, written out independently of the package so that a
    // wrong package constant shows up as a key mismatch.
    localparam word_t SEED_BASIS = 32'h6c078965;
    localparam word_t LEN_BASIS  = 32'h9908b0df;
    localparam word_t W2_BASIS   = 32'h9d2c5680;
    localparam word_t W3_BASIS   = 32'hefc60000;
    localparam word_t K_CHAR     = 32'h85ebca77;
    localparam word_t K_XOR_MUL  = 32'hcc9e2d51;
    localparam word_t K_CROSS    = 32'h1b873593;
    localparam word_t K_AVAL_P   = 32'h85ebca6b;
    localparam word_t K_AVAL_Q   = 32'hc2b2ae35;
    localparam word_t K_ROUND    = 32'h5bd1e995;
    localparam word_t K_ROUND_AD = 32'hffff0000;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_TAIL  = 64;      // idle margin after the last key
    localparam int RUN_LIMIT   = 2000000; // ns; a slow correct run is well under a third

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_value;
    logic        has_byte;
    logic        is_first;
    logic        is_last;
    logic [31:0] seed_word;
    logic [31:0] string_length;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] key_bytes;

    // Hash model state: the four mixing words and the byte index, zero out of reset.
    word_t       model_words [4] = '{default: '0};
    word_t       model_index = '0;

    logic [63:0] pending_keys [$];  // keys predicted but not yet seen on the output

    int unsigned transfers_in = 0;
    int unsigned strings_sent = 0;
    int unsigned keys_checked = 0;
    int unsigned mismatches   = 0;

    bit          src_idle  = 1'b1;  // sender inserts random gaps between transfers
    bit          sink_idle = 1'b1;  // receiver drops out_ready at random
    int unsigned sink_stall = 0;

    string_hash_key_mixer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_value    (byte_value),
        .has_byte      (has_byte),
        .is_first      (is_first),
        .is_last       (is_last),
        .seed_word     (seed_word),
        .string_length (string_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .key_bytes     (key_bytes)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly back-to-back, sometimes a few cycles, now and then a long hold-off.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic void report_miss(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%t %s: expected key %016h, got %016h", $realtime, what, want, got);
    endfunction

    // Applies one accepted transfer to the hash model: load on first, absorb the byte if
    // valid, then the eight finalisation rounds on last, queuing the resulting key.
    task automatic hash_predict(input logic [7:0] b, input logic hb, input logic first,
                                input logic last, input word_t seed, input word_t len);
        logic [1:0]  cur;
        logic [1:0]  nxt;
        logic [1:0]  wa;
        logic [1:0]  wb;
        logic [1:0]  wc;
        word_t       p;
        word_t       q;
        word_t       t;
        logic [63:0] key;
        int unsigned j;
        if (first)
        begin
            model_words[0] = SEED_BASIS ^ seed;
            model_words[1] = LEN_BASIS ^ len;
            model_words[2] = W2_BASIS;
            model_words[3] = W3_BASIS;
            model_index    = '0;
        end
        if (hb)
        begin
            cur = model_index[1:0];
            nxt = cur + 2'd1;
            model_words[cur] = {model_words[cur][24:0], model_words[cur][31:25]};
            model_words[cur] = model_words[cur] ^ ({24'd0, b} * K_CHAR);
            // pair mix: next word takes the role of x, current word of y, index as salt
            p = model_words[nxt];
            q = model_words[cur];
            p = (p ^ q) * K_XOR_MUL + model_index;
            q = (q ^ p) * K_CROSS;
            p = (p ^ (p >> 16)) * K_AVAL_P;
            q = (q ^ (q >> 13)) * K_AVAL_Q;
            model_words[nxt] = p;
            model_words[cur] = q;
            model_index = model_index + 32'd1;
        end
        if (last)
        begin
            for (j = 0; j < 8; j++)
            begin
                wa = 2'(j);
                wb = 2'(j + 1);
                wc = 2'(j + 2);
                t = model_words[wa] ^ (model_words[wb] << 11);
                model_words[wc] = model_words[wc] ^ (t >> 8);
                model_words[wa] = t * K_ROUND + K_ROUND_AD;
            end
            // key byte j comes from word j mod 4, byte lane j/2
            for (j = 0; j < 8; j++)
            begin
                wa = 2'(j);
                key[8*j +: 8] = 8'(model_words[wa] >> (8 * (j / 2)));
            end
            pending_keys.push_back(key);
        end
    endtask

    // Offers one item on the input channel, holds it until the transfer, then updates the
    // model. Inputs move only at the falling edge; in_ready is looked at on the rising edge.
    // in_valid stays high on return, so the caller either sends again or lowers it.
    task automatic send_item(input logic [7:0] b, input logic hb, input logic first,
                             input logic last, input word_t seed, input word_t len);
        int unsigned gap;
        gap = src_idle ? pick_gap() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_value    = b;
        has_byte      = hb;
        is_first      = first;
        is_last       = last;
        seed_word     = seed;
        string_length = len;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        transfers_in++;
        hash_predict(b, hb, first, last, seed, len);
    endtask

    // Lowers in_valid and holds the sender back until every predicted key has come out.
    task automatic wait_for_keys();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_keys.size() != 0)
            @(posedge clk);
    endtask

    // One well-formed string of nbytes bytes with random seed. The length field is usually
    // the true count, sometimes any value. With holes set, byte-less transfers may lead, trail
    // or sit inside the string. Fields the block must ignore carry random values.
    task automatic send_string(input int unsigned nbytes, input bit holes);
        word_t       seed;
        word_t       len;
        bit          lead_empty;
        bit          tail_empty;
        int unsigned i;
        logic        first;
        seed = $urandom;
        len  = ($urandom_range(9) == 0) ? $urandom : nbytes;
        strings_sent++;
        if (nbytes == 0)
        begin
            send_item(8'($urandom), 1'b0, 1'b1, 1'b1, seed, len);
            return;
        end
        lead_empty = holes && ($urandom_range(7) == 0);
        tail_empty = holes && ($urandom_range(7) == 0);
        if (lead_empty)
            send_item(8'($urandom), 1'b0, 1'b1, 1'b0, seed, len);
        for (i = 0; i < nbytes; i++)
        begin
            if (holes && i > 0 && $urandom_range(9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, 1'b0, $urandom, $urandom);
            first = (i == 0) && !lead_empty;
            send_item(8'($urandom), 1'b1, first, (i == nbytes - 1) && !tail_empty,
                      first ? seed : word_t'($urandom), first ? len : word_t'($urandom));
        end
        if (tail_empty)
            send_item(8'($urandom), 1'b0, 1'b0, 1'b1, $urandom, $urandom);
    endtask

    // Mostly short strings; a few longer ones so the index runs well past one word cycle.
    function automatic int unsigned pick_length();
        return ($urandom_range(9) != 0) ? $urandom_range(12, 0) : $urandom_range(48, 13);
    endfunction

    // Hand-picked transfers: mixing before any first transfer and after a finished key,
    // empty strings at both ends of seed and length, single bytes at both extremes, byte-less
    // transfers at start, middle and end, a length that disagrees with the byte count, and a
    // string restarted before its last byte.
    task automatic test_directed();
        send_item(8'h00, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
        send_item(8'hff, 1'b1, 1'b0, 1'b1, 32'hffffffff, 32'hffffffff);
        send_item(8'h5a, 1'b1, 1'b0, 1'b1, 32'h0, 32'h0);
        send_item(8'h00, 1'b0, 1'b1, 1'b1, 32'h00000000, 32'h00000000);
        send_item(8'hff, 1'b0, 1'b1, 1'b1, 32'hffffffff, 32'hffffffff);
        send_item(8'h00, 1'b1, 1'b1, 1'b1, 32'h00000000, 32'h00000001);
        send_item(8'hff, 1'b1, 1'b1, 1'b1, 32'hffffffff, 32'hffffffff);
        send_item(8'h00, 1'b0, 1'b1, 1'b0, 32'h80000001, 32'h00000003);
        send_item(8'h01, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
        send_item(8'h80, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
        send_item(8'haa, 1'b0, 1'b0, 1'b0, 32'hffffffff, 32'hffffffff);
        send_item(8'hff, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
        send_item(8'h7f, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
        send_item(8'h55, 1'b0, 1'b0, 1'b1, 32'h0, 32'h0);
        send_item(8'h11, 1'b1, 1'b1, 1'b0, 32'h12345678, 32'h00000004);
        send_item(8'h22, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
        send_item(8'h33, 1'b1, 1'b1, 1'b0, 32'hfedcba98, 32'h00000002);
        send_item(8'h44, 1'b1, 1'b0, 1'b1, 32'h0, 32'h0);
        strings_sent += 8;
    endtask

    // Random well-formed strings with random content, under random idling on both sides.
    task automatic test_random_strings(input int unsigned upto);
        while (transfers_in < upto)
            send_string(pick_length(), 1'($urandom_range(1)));
    endtask

    // Short bursts of strings with the sender waiting for every key between bursts.
    task automatic test_drain_pause(input int unsigned upto);
        while (transfers_in < upto)
        begin
            repeat ($urandom_range(3, 1))
                send_string($urandom_range(6, 0), 1'b1);
            wait_for_keys();
        end
    endtask

    // Unstructured transfers: every flag combination, random seed and length everywhere.
    task automatic test_noise(input int unsigned upto);
        while (transfers_in < upto)
            send_item(8'($urandom), 1'($urandom_range(1)), $urandom_range(3) == 0,
                      $urandom_range(3) == 0, $urandom, $urandom);
    endtask

    // No idling on either side: transfers back to back and keys taken at once.
    task automatic test_back_to_back(input int unsigned upto);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        while (transfers_in < upto)
            send_string(pick_length(), 1'($urandom_range(1)));
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // Receiver: out_ready moves at the falling edge, stalls of random length.
    always @(negedge clk)
    begin
        if (!sink_idle)
            out_ready <= 1'b1;
        else if (sink_stall != 0)
        begin
            out_ready  <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            sink_stall <= pick_gap();
        end
    end

    // Key checker: every output transfer against the oldest predicted key.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_keys.size() == 0)
                report_miss("key transfer with none expected", 64'h0, key_bytes);
            else
            begin
                keys_checked++;
                if (key_bytes !== pending_keys[0])
                    report_miss("key mismatch", pending_keys[0], key_bytes);
                void'(pending_keys.pop_front());
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        byte_value    = '0;
        has_byte      = 1'b0;
        is_first      = 1'b0;
        is_last       = 1'b0;
        seed_word     = '0;
        string_length = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_strings(650);
        test_drain_pause(800);
        test_noise(950);
        test_back_to_back(1100);

        wait_for_keys();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Sent %0d transfers in %0d strings plus random noise, with idling on both sides",
                 transfers_in, strings_sent);
        $display("Checked %0d keys, %0d failures", keys_checked, mismatches);
        if (mismatches == 0 && pending_keys.size() == 0)
            $display("string_hash_key_mixer: match");
        else
            $display("string_hash_key_mixer: mismatch");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #RUN_LIMIT;
        $display("Timed out with %0d keys still expected", pending_keys.size());
        $display("string_hash_key_mixer: mismatch");
        $finish;
    end

endmodule
